// ===== hw/rtl/cscan_disk_request_scheduler_defines.svh =====
// Assertion macros used by the checker file of the scheduler.
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CSCAN_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("cscan: check failed");

// Next-cycle implication, held off while reset is asserted.
`define CSCAN_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("cscan: check failed");

`endif

// ===== hw/rtl/cscan_pkg.sv =====
`timescale 1ns / 1ps
package cscan_pkg;

  localparam int MAX_REQUESTS_DEF = 32;

  localparam int TRACK_W   = 16;
  localparam int DISK_W    = 17;
  localparam int MOVE_W    = 18;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TRACK = 1'd1;

  localparam logic [DISK_W-1:0]  DISK_SIZE_RST   = 17'd200;
  localparam logic [DISK_W-1:0]  DISK_SIZE_MAX   = 17'd65536;
  localparam logic [TRACK_W-1:0] START_TRACK_RST = 16'd0;

  typedef logic [TRACK_W-1:0]   track_t;
  typedef logic [MOVE_W-1:0]    move_t;
  typedef logic [DISK_W-1:0]    disk_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic batch_start;
    logic scan_run;
    logic commit;
    logic batch_end;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic all_served;
  } dp_sts_t;

  // Highest track: a size of zero acts as one, anything above 65536 as 65536
  function automatic track_t top_of(input disk_t size);
    track_t top;
    if (size == '0) begin
      top = '0;
    end else if (size > DISK_SIZE_MAX) begin
      top = '1;
    end else begin
      top = TRACK_W'(size - disk_t'(1));
    end
    return top;
  endfunction

endpackage

// ===== hw/rtl/cscan_ifs.sv =====
`timescale 1ns / 1ps
interface cscan_req_if;
  import cscan_pkg::*;
  logic   valid;
  logic   ready;
  track_t request_track;
  logic   last;
  modport source (output valid, output request_track, output last, input ready);
  modport sink   (input valid, input request_track, input last, output ready);
endinterface

interface cscan_res_if;
  import cscan_pkg::*;
  logic   valid;
  logic   ready;
  track_t served_track;
  move_t  total_movement;
  logic   end_of_batch;
  logic   overflow;
  modport source (output valid, output served_track, output total_movement,
                  output end_of_batch, output overflow, input ready);
  modport sink   (input valid, input served_track, input total_movement,
                  input end_of_batch, input overflow, output ready);
endinterface

interface cscan_cfg_if;
  import cscan_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  disk_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cscan_dp.sv =====
`timescale 1ns / 1ps
module cscan_dp #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  cscan_pkg::cfg_idx_t cfg_index,
  input  cscan_pkg::disk_t    cfg_data,
  input  cscan_pkg::track_t   in_track,
  input  cscan_pkg::dp_cmd_t  cmd,
  output cscan_pkg::dp_sts_t  sts,
  output cscan_pkg::track_t   out_track,
  output cscan_pkg::move_t    out_move,
  output logic                out_end,
  output logic                out_ovf
);
  import cscan_pkg::*;

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int KEY_W = TRACK_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Configuration
  disk_t  disk_size_r;
  track_t start_track_r;

  // Request store and batch bookkeeping
  track_t                  mem_r [MAX_REQUESTS];
  logic [CNT_W-1:0]        count_r;
  logic                    dropped_r;
  logic [MAX_REQUESTS-1:0] served_r;
  logic [CNT_W-1:0]        served_cnt_r;

  // Walk state
  track_t top_r;
  track_t head0_r;
  track_t head_r;
  move_t  moved_r;
  logic   wrapped_r;

  // Scan pipeline
  logic [CNT_W-1:0] sc_r;
  logic             rvld_r;
  logic [IDX_W-1:0] ridx_r;
  track_t           rdata_r;
  logic             best_vld_r;
  logic [KEY_W-1:0] best_key_r;
  logic [IDX_W-1:0] best_idx_r;

  track_t           top_now;
  track_t           cmp_trk;
  logic [KEY_W-1:0] cmp_key;
  logic             better;
  logic             issue;
  logic [KEY_W-1:0] best_key_nxt;
  logic [IDX_W-1:0] best_idx_nxt;
  track_t           sel_trk;
  logic             sel_below;
  move_t            move_add;
  move_t            moved_nxt;

  assign top_now = top_of(disk_size_r);
  assign issue   = cmd.scan_run && (sc_r < count_r);

  // Entries below the start track sort after all others
  assign cmp_trk = (rdata_r > top_r) ? top_r : rdata_r;
  assign cmp_key = {cmp_trk < head0_r, cmp_trk};
  assign better  = rvld_r && !served_r[ridx_r] && (!best_vld_r || (cmp_key < best_key_r));

  assign best_key_nxt = better ? cmp_key : best_key_r;
  assign best_idx_nxt = better ? ridx_r  : best_idx_r;
  assign sel_trk      = best_key_nxt[TRACK_W-1:0];
  assign sel_below    = best_key_nxt[TRACK_W];

  // First entry below the start: run to the top, return to zero, then seek
  always_comb begin
    if (sel_below && !wrapped_r) begin
      move_add = MOVE_W'(top_r - head_r) + MOVE_W'(top_r) + MOVE_W'(sel_trk);
    end else begin
      move_add = MOVE_W'(sel_trk - head_r);
    end
  end
  assign moved_nxt = moved_r + move_add;

  assign sts.scan_done  = rvld_r && ((CNT_W'(ridx_r) + CNT_ONE) == count_r);
  assign sts.all_served = (served_cnt_r == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r   <= DISK_SIZE_RST;
      start_track_r <= START_TRACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISK_SIZE:   disk_size_r   <= cfg_data;
        REG_START_TRACK: start_track_r <= cfg_data[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNT_MAX)) begin
      mem_r[count_r[IDX_W-1:0]] <= in_track;
    end
    if (issue) begin
      rdata_r <= mem_r[sc_r[IDX_W-1:0]];
      ridx_r  <= sc_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      dropped_r    <= 1'b0;
      served_r     <= '0;
      served_cnt_r <= '0;
      wrapped_r    <= 1'b0;
      sc_r         <= '0;
      rvld_r       <= 1'b0;
      best_vld_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (count_r < CNT_MAX) begin
          count_r <= count_r + CNT_ONE;
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.batch_end) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.batch_start) begin
        served_r     <= '0;
        served_cnt_r <= '0;
        wrapped_r    <= 1'b0;
        sc_r         <= '0;
        rvld_r       <= 1'b0;
        best_vld_r   <= 1'b0;
      end else if (cmd.commit) begin
        served_r[best_idx_nxt] <= 1'b1;
        served_cnt_r           <= served_cnt_r + CNT_ONE;
        wrapped_r              <= wrapped_r | sel_below;
        sc_r                   <= '0;
        rvld_r                 <= 1'b0;
        best_vld_r             <= 1'b0;
      end else begin
        rvld_r <= issue;
        if (issue) begin
          sc_r <= sc_r + CNT_ONE;
        end
        if (better) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.batch_start) begin
      top_r   <= top_now;
      head0_r <= (start_track_r > top_now) ? top_now : start_track_r;
      head_r  <= (start_track_r > top_now) ? top_now : start_track_r;
      moved_r <= '0;
    end else if (cmd.commit) begin
      head_r  <= sel_trk;
      moved_r <= moved_nxt;
    end
    if (better) begin
      best_key_r <= cmp_key;
      best_idx_r <= ridx_r;
    end
    if (cmd.commit) begin
      out_track <= sel_trk;
      out_move  <= moved_nxt;
      out_end   <= ((served_cnt_r + CNT_ONE) == count_r);
      out_ovf   <= dropped_r;
    end
  end

endmodule

// ===== hw/rtl/cscan_ctrl.sv =====
`timescale 1ns / 1ps
module cscan_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cscan_pkg::dp_sts_t sts,
  output cscan_pkg::dp_cmd_t cmd
);
  import cscan_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.batch_start = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.all_served) begin
            cmd.batch_end = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/cscan_disk_request_scheduler.sv =====
`timescale 1ns / 1ps
// C-SCAN disk request scheduler. Requests load one per cycle, while no batch
// is being served, into a store of MAX_REQUESTS entries; requests beyond that
// are dropped and every result of that batch carries overflow. The transfer
// marked last closes the batch: the block then serves the stored tracks (each
// clamped to the top track of the current disk_size) in ascending order from
// start_track upward, runs to the top track, returns to track 0 and serves
// the rest, reporting each served track with the cumulative head movement;
// end_of_batch marks the final one. Each result costs one pass over the store
// through its single read port and is then offered until taken; the next
// request is taken only once the whole batch has been served. Configuration
// writes are always taken and must be made while no batch is being served.
module cscan_disk_request_scheduler #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  cscan_req_if.sink   in_req,
  cscan_res_if.source out_res,
  cscan_cfg_if.sink   cfg_wr
);
  import cscan_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  // Configuration registers never stall
  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = in_ready;
  assign out_res.valid = out_valid;

  // Sequence loading, scan passes and result hand-off
  cscan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_last   (in_req.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the store, pick the next track per pass and advance the head
  cscan_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .in_track  (in_req.request_track),
    .cmd       (cmd),
    .sts       (sts),
    .out_track (out_res.served_track),
    .out_move  (out_res.total_movement),
    .out_end   (out_res.end_of_batch),
    .out_ovf   (out_res.overflow)
  );

endmodule

// ===== hw/rtl/cscan_chk.sv =====
`timescale 1ns / 1ps
`include "cscan_disk_request_scheduler_defines.svh"
module cscan_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input cscan_pkg::track_t out_track,
  input cscan_pkg::move_t  out_move,
  input logic              out_end,
  input logic              out_ovf
);
  import cscan_pkg::*;

  // Never take a request while a result is on offer
  `CSCAN_ASSERT_IMP(a_no_load_while_emit, clk, rst_n, out_valid, !in_ready)
  // Closing a batch stops loading until the batch is served
  `CSCAN_ASSERT_NXT(a_last_stalls, clk, rst_n, in_valid && in_ready && in_last, !in_ready && !out_valid)
  // Final result of a batch returns the block to loading
  `CSCAN_ASSERT_NXT(a_end_reloads, clk, rst_n, out_valid && out_ready && out_end, in_ready && !out_valid)
  // A stalled result holds its payload
  `CSCAN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_track, out_move, out_end, out_ovf}))

endmodule

bind cscan_disk_request_scheduler cscan_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .in_last   (in_req.last),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_track (out_res.served_track),
  .out_move  (out_res.total_movement),
  .out_end   (out_res.end_of_batch),
  .out_ovf   (out_res.overflow)
);
